// ----- design/ple_pkg.sv -----
// Shared types and constants for the positional list engine.
// Used by ple_cell and positional_list_engine; depends on nothing else.
package ple_pkg;

    // Number of cells in the list (2 to 63).
    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 6;

    // Request codes carried by the action field.
    typedef enum logic [2:0] {
        ACT_APPEND     = 3'd0,
        ACT_INSERT     = 3'd1,
        ACT_DELETE_END = 3'd2,
        ACT_DELETE_POS = 3'd3,
        ACT_READ_OUT   = 3'd4,
        ACT_COUNT      = 3'd5
    } action_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CK_HOLD,
        CK_APPEND,
        CK_INSERT,
        CK_DELETE,
        CK_ROTATE
    } cell_kind_t;

    typedef struct packed {
        cell_kind_t               kind;
        logic [POS_W-1:0]         pos_m1;   // zero-based position
        logic [LEN_W-1:0]         len;      // length before the operation
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

// ----- design/ple_cell.sv -----
// One storage cell of the positional list engine chain.
// Depends on ple_pkg for the broadcast command type and widths.
module ple_cell (
    input  logic                              aclk,
    input  logic [ple_pkg::IDX_W-1:0]         cell_index,
    input  ple_pkg::cell_cmd_t                cmd,
    input  logic signed [ple_pkg::DATA_W-1:0] left_data,
    input  logic signed [ple_pkg::DATA_W-1:0] right_data,
    input  logic signed [ple_pkg::DATA_W-1:0] head_data,
    output logic signed [ple_pkg::DATA_W-1:0] data
);
    import ple_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic [LEN_W-1:0]         idx_len;
    logic [LEN_W-1:0]         idx_len_p1;
    logic [POS_W-1:0]         idx_pos;

    assign idx_len    = LEN_W'(cell_index);
    assign idx_len_p1 = LEN_W'(idx_len + LEN_W'(1));
    assign idx_pos    = POS_W'(cell_index);

    // Pick the new content from the command and this cell's place in the row.
    always_comb begin
        data_next = data_reg;
        unique case (cmd.kind)
            CK_APPEND: begin
                if (idx_len == cmd.len) data_next = cmd.value;
            end
            CK_INSERT: begin
                if (idx_pos == cmd.pos_m1) begin
                    data_next = cmd.value;
                end else if (idx_pos > cmd.pos_m1 && idx_len <= cmd.len) begin
                    data_next = left_data;
                end
            end
            CK_DELETE: begin
                if (idx_pos >= cmd.pos_m1 && idx_len_p1 < cmd.len) data_next = right_data;
            end
            CK_ROTATE: begin
                if (idx_len_p1 < cmd.len) begin
                    data_next = right_data;
                end else if (idx_len_p1 == cmd.len) begin
                    data_next = head_data;
                end
            end
            default: data_next = data_reg;
        endcase
    end

    // Entry storage; content is undefined until written.
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- design/positional_list_engine.sv -----
// Positional list engine: an ordered list held in a chain of shifting cells.
// An accepted request's result is in the output register the next cycle; a read-out
// first enters the read state, which then streams its entries from the head cell.
// Throughput: one request per cycle while idle with the output register free.
// Reset (aresetn low, synchronous) empties the list and clears the output valid.
// Depends on ple_pkg and ple_cell.
module positional_list_engine (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_action,
    input  logic [ple_pkg::POS_W-1:0]          s_position,
    input  logic signed [ple_pkg::DATA_W-1:0]  s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [ple_pkg::DATA_W-1:0]  m_item_value,
    output logic [ple_pkg::COUNT_W-1:0]        m_item_count,
    output logic [1:0]                         m_status,
    output logic                               m_last_of_run
);
    import ple_pkg::*;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'b01,
        FSM_READ = 2'b10
    } fsm_t;

    fsm_t                     state_reg, state_next;
    logic [LEN_W-1:0]         length_reg, length_next;
    logic [LEN_W-1:0]         rd_cnt_reg, rd_cnt_next;
    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_value_reg, m_value_next;
    logic [COUNT_W-1:0]       m_count_reg, m_count_next;
    status_t                  m_status_reg, m_status_next;
    logic                     m_last_reg, m_last_next;

    cell_cmd_t                cmd;
    logic signed [DATA_W-1:0] cell_data [CAPACITY];

    logic                     out_free;
    logic                     accept;
    logic [POS_W:0]           pos_ext;
    logic [POS_W:0]           len_ext;
    logic                     list_full;
    logic                     list_empty;
    logic                     rd_last;
    status_t                  st;

    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == FSM_IDLE) && out_free;
    assign accept     = s_valid && s_ready;
    assign pos_ext    = (POS_W + 1)'(s_position);
    assign len_ext    = (POS_W + 1)'(length_reg);
    assign list_full  = (length_reg == LEN_W'(CAPACITY));
    assign list_empty = (length_reg == '0);
    assign rd_last    = (LEN_W'(rd_cnt_reg + LEN_W'(1)) == length_reg);

    // Request decode, cell command and output register loading.
    always_comb begin
        state_next    = state_reg;
        length_next   = length_reg;
        rd_cnt_next   = rd_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_value_next  = m_value_reg;
        m_count_next  = m_count_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        st            = STAT_OK;
        cmd.kind      = CK_HOLD;
        cmd.pos_m1    = POS_W'(s_position - POS_W'(1));
        cmd.len       = length_reg;
        cmd.value     = s_value;

        unique case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    unique case (s_action)
                        ACT_APPEND: begin
                            if (list_full) begin
                                st = STAT_FULL;
                            end else begin
                                cmd.kind    = CK_APPEND;
                                length_next = LEN_W'(length_reg + LEN_W'(1));
                            end
                        end
                        ACT_INSERT: begin
                            if (s_position == '0 || pos_ext > len_ext + (POS_W + 1)'(1)) begin
                                st = STAT_RANGE;
                            end else if (list_full) begin
                                st = STAT_FULL;
                            end else begin
                                cmd.kind    = CK_INSERT;
                                length_next = LEN_W'(length_reg + LEN_W'(1));
                            end
                        end
                        ACT_DELETE_END: begin
                            if (list_empty) begin
                                st = STAT_EMPTY;
                            end else begin
                                length_next = LEN_W'(length_reg - LEN_W'(1));
                            end
                        end
                        ACT_DELETE_POS: begin
                            if (list_empty) begin
                                st = STAT_EMPTY;
                            end else if (s_position == '0 || pos_ext > len_ext) begin
                                st = STAT_RANGE;
                            end else begin
                                cmd.kind    = CK_DELETE;
                                length_next = LEN_W'(length_reg - LEN_W'(1));
                            end
                        end
                        ACT_READ_OUT: begin
                            if (list_empty) begin
                                st = STAT_EMPTY;
                            end
                        end
                        default: st = STAT_OK;
                    endcase

                    if (s_action == ACT_READ_OUT && !list_empty) begin
                        // Entries are streamed from the head cell in the read state.
                        state_next  = FSM_READ;
                        rd_cnt_next = '0;
                    end else begin
                        m_valid_next  = 1'b1;
                        m_value_next  = '0;
                        m_count_next  = COUNT_W'(length_next);
                        m_status_next = st;
                        m_last_next   = 1'b1;
                    end
                end
            end
            FSM_READ: begin
                // Emit the head entry and rotate the occupied cells by one.
                if (out_free) begin
                    cmd.kind      = CK_ROTATE;
                    m_valid_next  = 1'b1;
                    m_value_next  = cell_data[0];
                    m_count_next  = COUNT_W'(length_reg);
                    m_status_next = STAT_OK;
                    m_last_next   = rd_last;
                    rd_cnt_next   = LEN_W'(rd_cnt_reg + LEN_W'(1));
                    if (rd_last) state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            length_reg  <= '0;
            rd_cnt_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            length_reg  <= length_next;
            rd_cnt_reg  <= rd_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload registers.
    always_ff @(posedge aclk) begin
        m_value_reg  <= m_value_next;
        m_count_reg  <= m_count_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    // Chain of storage cells, each linked to both neighbors and the head.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        ple_cell u_cell (
            .aclk       (aclk),
            .cell_index (IDX_W'(i)),
            .cmd        (cmd),
            .left_data  (cell_data[(i + CAPACITY - 1) % CAPACITY]),
            .right_data (cell_data[(i + 1) % CAPACITY]),
            .head_data  (cell_data[0]),
            .data       (cell_data[i])
        );
    end

    assign m_valid       = m_valid_reg;
    assign m_item_value  = m_value_reg;
    assign m_item_count  = m_count_reg;
    assign m_status      = m_status_reg;
    assign m_last_of_run = m_last_reg;

`ifndef NO_ASSERTIONS
    // The list never grows beyond the number of cells.
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        length_reg <= LEN_W'(CAPACITY))
        else $error("list length exceeds capacity");

    // During a read-out the entry counter stays below the length and no request is accepted.
    a_rd_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == FSM_READ |-> rd_cnt_reg < length_reg && s_ready == 1'b0)
        else $error("read-out counter out of range");

    // The length does not change while a read-out is in progress.
    a_len_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == FSM_READ |=> length_reg == $past(length_reg))
        else $error("length changed during read-out");

    // An empty-list status always reports a zero count.
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_EMPTY |-> m_item_count == '0)
        else $error("empty status with nonzero count");
`endif

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for positional_list_engine: directed table, then random requests.
// Depends on ple_pkg and the positional_list_engine RTL; predicts every result internally.
`timescale 1ns / 100ps

module tb;
    import ple_pkg::*;

    localparam int  CLK_PERIOD  = 20;
    localparam int  DRAIN_TAIL  = 8;
    localparam int  ITEMS_PHASE = 88;
    localparam real TIMEOUT_NS  = 20_000_000.0;

    // Action codes the block treats like a count.
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [COUNT_W-1:0]       count;
        status_t                  status;
        logic                     last;
    } list_result_t;

    typedef struct {
        logic [2:0]               action;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
        bit                       fixed;
        list_result_t             want;
    } request_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [2:0]                s_action;
    logic [POS_W-1:0]          s_position;
    logic signed [DATA_W-1:0]  s_value;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [DATA_W-1:0]  m_item_value;
    logic [COUNT_W-1:0]        m_item_count;
    logic [1:0]                m_status;
    logic                      m_last_of_run;

    // Mirror of the list contents and the pending results.
    logic signed [DATA_W-1:0]  list_cells [CAPACITY];
    int                        list_len = 0;
    list_result_t              pending_results [$];
    request_row_t              directed_rows [$];

    // Literal result for the request currently on the input channel.
    bit                        row_fixed = 1'b0;
    list_result_t              row_want;

    int                        fail_count = 0;
    int                        idle_pct = 0;
    int                        stall_pct = 0;
    bit                        grow_mode = 1'b1;

    positional_list_engine dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_position    (s_position),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item_value  (m_item_value),
        .m_item_count  (m_item_count),
        .m_status      (m_status),
        .m_last_of_run (m_last_of_run)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Updates the list mirror for one request and queues the results it causes.
    function automatic void apply_list_request(logic [2:0] act, logic [POS_W-1:0] pos,
                                               logic signed [DATA_W-1:0] val);
        status_t      st;
        list_result_t res;
        int           i;
        st = STAT_OK;
        case (act)
            ACT_APPEND: begin
                if (list_len >= CAPACITY) begin
                    st = STAT_FULL;
                end else begin
                    list_cells[list_len] = val;
                    list_len++;
                end
            end
            ACT_INSERT: begin
                if (pos == 0 || int'(pos) > list_len + 1) begin
                    st = STAT_RANGE;
                end else if (list_len >= CAPACITY) begin
                    st = STAT_FULL;
                end else begin
                    for (i = list_len; i > int'(pos) - 1; i--)
                        list_cells[i] = list_cells[i-1];
                    list_cells[int'(pos) - 1] = val;
                    list_len++;
                end
            end
            ACT_DELETE_END: begin
                if (list_len == 0)
                    st = STAT_EMPTY;
                else
                    list_len--;
            end
            ACT_DELETE_POS: begin
                if (list_len == 0) begin
                    st = STAT_EMPTY;
                end else if (pos == 0 || int'(pos) > list_len) begin
                    st = STAT_RANGE;
                end else begin
                    for (i = int'(pos) - 1; i + 1 < list_len; i++)
                        list_cells[i] = list_cells[i+1];
                    list_len--;
                end
            end
            ACT_READ_OUT: begin
                if (list_len == 0) begin
                    st = STAT_EMPTY;
                end else begin
                    for (i = 0; i < list_len; i++) begin
                        res.value  = list_cells[i];
                        res.count  = COUNT_W'(list_len);
                        res.status = STAT_OK;
                        res.last   = (i + 1 == list_len);
                        pending_results.push_back(res);
                    end
                    return;
                end
            end
            default: ;
        endcase
        res.value  = '0;
        res.count  = COUNT_W'(list_len);
        res.status = st;
        res.last   = 1'b1;
        pending_results.push_back(res);
    endfunction

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    // Both channels are sampled at the rising edge, before the block updates.
    always @(posedge aclk) begin : result_monitor
        list_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                apply_list_request(s_action, s_position, s_value);
                if (row_fixed) begin
                    void'(pending_results.pop_back());
                    pending_results.push_back(row_want);
                end
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    note_failure($sformatf(
                        "unexpected result: value %0d count %0d status %0d last %0b",
                        m_item_value, m_item_count, m_status, m_last_of_run));
                end else begin
                    want = pending_results.pop_front();
                    if (m_item_value !== want.value || m_item_count !== want.count ||
                        m_status !== want.status || m_last_of_run !== want.last)
                        note_failure({$sformatf(
                            "mismatch: expected value %0d count %0d status %0d last %0b,",
                            want.value, want.count, want.status, want.last),
                            $sformatf(" got value %0d count %0d status %0d last %0b",
                            m_item_value, m_item_count, m_status, m_last_of_run)});
                end
            end
        end
    end

    // Result channel backpressure, redrawn at every falling edge.
    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= stall_pct);
    end

    task automatic add_row(logic [2:0] act, int pos, logic signed [DATA_W-1:0] val,
                           bit fixed, int cnt, status_t st);
        request_row_t row;
        row.action      = act;
        row.position    = POS_W'(pos);
        row.value       = val;
        row.fixed       = fixed;
        row.want.value  = '0;
        row.want.count  = COUNT_W'(cnt);
        row.want.status = st;
        row.want.last   = 1'b1;
        directed_rows.push_back(row);
    endtask

    // Drives one transaction from a falling edge and returns at the falling edge after it.
    task automatic send_request(logic [2:0] act, logic [POS_W-1:0] pos,
                                logic signed [DATA_W-1:0] val, bit fixed, list_result_t want);
        while ($urandom_range(99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_action   = act;
        s_position = pos;
        s_value    = val;
        row_fixed  = fixed;
        row_want   = want;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    // Random request that swings the list between empty and full.
    task automatic pick_request(output logic [2:0] act, output logic [POS_W-1:0] pos,
                                output logic signed [DATA_W-1:0] val);
        int roll;
        int grow_top;
        if (grow_mode && list_len == CAPACITY && $urandom_range(3) == 0)
            grow_mode = 1'b0;
        else if (!grow_mode && list_len == 0 && $urandom_range(2) == 0)
            grow_mode = 1'b1;
        grow_top = grow_mode ? 80 : 35;
        roll = $urandom_range(99);
        if (roll < 8)
            act = ACT_READ_OUT;
        else if (roll < 13)
            act = ACT_COUNT;
        else if (roll < 15)
            act = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
        else if (roll < grow_top)
            act = $urandom_range(1) ? ACT_INSERT : ACT_APPEND;
        else
            act = $urandom_range(1) ? ACT_DELETE_POS : ACT_DELETE_END;

        // Mostly legal positions, with the whole field range now and then.
        if (act == ACT_INSERT && $urandom_range(99) < 85)
            pos = POS_W'($urandom_range(list_len + 1, 1));
        else if (act == ACT_DELETE_POS && list_len > 0 && $urandom_range(99) < 85)
            pos = POS_W'($urandom_range(list_len, 1));
        else
            pos = POS_W'($urandom_range(255));

        if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
                0: val = 32'sh7FFFFFFF;
                1: val = 32'sh80000000;
                2: val = '0;
                default: val = -32'sd1;
            endcase
        end else begin
            val = $urandom;
        end
    endtask

    initial begin
        #TIMEOUT_NS;
        $display("tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [2:0]               act;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        list_result_t             none;
        int                       ph;
        int                       n;

        none       = '0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_action   = ACT_COUNT;
        s_position = '0;
        s_value    = '0;
        m_ready    = 1'b0;

        // Directed requests: empty-list cases, bad positions, extremes, every action.
        add_row(ACT_COUNT,      0,   0,            1, 0, STAT_OK);
        add_row(ACT_READ_OUT,   0,   0,            1, 0, STAT_EMPTY);
        add_row(ACT_DELETE_END, 0,   0,            1, 0, STAT_EMPTY);
        add_row(ACT_DELETE_POS, 1,   0,            1, 0, STAT_EMPTY);
        add_row(ACT_INSERT,     0,   5,            1, 0, STAT_RANGE);
        add_row(ACT_INSERT,     2,   5,            1, 0, STAT_RANGE);
        add_row(ACT_INSERT,     1,   32'sh7FFFFFFF, 1, 1, STAT_OK);
        add_row(ACT_APPEND,     0,   32'sh80000000, 1, 2, STAT_OK);
        add_row(ACT_APPEND,     255, -32'sd1,      0, 0, STAT_OK);
        add_row(ACT_INSERT,     4,   0,            0, 0, STAT_OK);
        add_row(ACT_INSERT,     2,   12345,        0, 0, STAT_OK);
        add_row(ACT_READ_OUT,   0,   0,            0, 0, STAT_OK);
        add_row(ACT_DELETE_POS, 0,   0,            1, 5, STAT_RANGE);
        add_row(ACT_DELETE_POS, 6,   0,            1, 5, STAT_RANGE);
        add_row(ACT_DELETE_POS, 255, -32'sd1,      1, 5, STAT_RANGE);
        add_row(ACT_INSERT,     255, -32'sd1,      1, 5, STAT_RANGE);
        add_row(ACT_DELETE_POS, 5,   0,            0, 0, STAT_OK);
        add_row(ACT_DELETE_POS, 1,   0,            0, 0, STAT_OK);
        add_row(ACT_SPARE_LO,   0,   0,            0, 0, STAT_OK);
        add_row(ACT_SPARE_HI,   255, -32'sd1,      0, 0, STAT_OK);
        add_row(ACT_DELETE_END, 0,   0,            0, 0, STAT_OK);
        add_row(ACT_READ_OUT,   0,   0,            0, 0, STAT_OK);
        add_row(ACT_COUNT,      0,   0,            0, 0, STAT_OK);

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].action, directed_rows[i].position,
                         directed_rows[i].value, directed_rows[i].fixed, directed_rows[i].want);

        // Random requests over four idling phases.
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 76; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 76; end
                default: begin idle_pct = 12; stall_pct = 12; end
            endcase
            for (n = 0; n < ITEMS_PHASE; n++) begin
                pick_request(act, pos, val);
                send_request(act, pos, val, 1'b0, none);
            end
        end
        s_valid = 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
